// ===== design/cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper with irq.
// ----------------------------------------------------------------------------
package cbm_pkg;

   typedef enum logic [1:0] {
      FUNC_CPU_WRITE = 2'd0,
      FUNC_CPU_READ  = 2'd1,
      FUNC_PPU_READ  = 2'd2,
      FUNC_CPU_TICK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_CHR_IS_512K    = 2'd0,
      CSR_WRAM_WRITABLE  = 2'd1,
      CSR_SWITCH_PRESENT = 2'd2,
      CSR_REGION_ASIA    = 2'd3
   } csr_index_type;

   // register groups inside the 8000-8fff window, address bits 9..8
   localparam logic [1:0] GRP_OUTER   = 2'd0;
   localparam logic [1:0] GRP_CONTROL = 2'd1;
   localparam logic [1:0] GRP_IRQ     = 2'd2;
   localparam logic [1:0] GRP_BANKS   = 2'd3;

   localparam logic [6:0] TOP_WINDOW_RESET = 7'h1F;
   localparam logic [4:0] FIXED_WINDOW_BANK = 5'h1F;

   typedef struct packed {
      logic chr_is_512k;
      logic wram_writable;
      logic switch_present;
      logic region_asia;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        data_valid;
      logic        rom_read;
      logic [19:0] rom_address;
      logic [19:0] chr_address;
      logic [1:0]  mirroring;
      logic        irq;
   } result_type;

endpackage

// ===== design/cbm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state and the combinational decode of one item: register writes,
// read answers, prg/chr address translation and the irq counter.
// ----------------------------------------------------------------------------
module cbm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  cbm_pkg::func_type  func,
   input  logic [15:0]        address,
   input  logic [7:0]         write_data,
   input  cbm_pkg::cfg_type   cfg,
   output cbm_pkg::result_type result
);

   logic [7:0]  control_reg_ff, control_reg_in;
   logic [4:0]  prg_regs_ff [4];
   logic [4:0]  prg_regs_in [4];
   logic [7:0]  outer_bank_ff, outer_bank_in;
   logic [7:0]  scratch_byte_ff, scratch_byte_in;
   logic [9:0]  chr_banks_ff [8];
   logic [9:0]  chr_banks_in [8];
   logic [6:0]  top_window_bank_ff, top_window_bank_in;
   logic [15:0] irq_count_ff, irq_count_in;
   logic        irq_enabled_ff, irq_enabled_in;
   logic        irq_line_ff, irq_line_in;

   logic        in_scratch;
   logic        in_outer_alias;
   logic        in_reg_window;
   logic [1:0]  grp;
   logic [4:0]  lo;
   logic [2:0]  chr_slot_pair;
   logic [15:0] count_step;
   logic [6:0]  prg_bank;
   logic [4:0]  window_bank;
   logic [12:0] ppu_offset;

   assign in_scratch     = (address[15:8] == 8'h51);
   assign in_outer_alias = (address == 16'hB000) || (address == 16'hB0FF) ||
                           (address == 16'hB100);
   assign in_reg_window  = (address[15:12] == 4'h8);
   assign grp            = address[9:8];
   assign lo             = address[4:0];
   assign chr_slot_pair  = {address[1:0], 1'b0};
   assign count_step     = control_reg_ff[6] ? (irq_count_ff - 16'd1)
                                             : (irq_count_ff + 16'd1);

   // next state
   always_comb begin
      control_reg_in     = control_reg_ff;
      prg_regs_in        = prg_regs_ff;
      outer_bank_in      = outer_bank_ff;
      scratch_byte_in    = scratch_byte_ff;
      chr_banks_in       = chr_banks_ff;
      irq_count_in       = irq_count_ff;
      irq_enabled_in     = irq_enabled_ff;
      irq_line_in        = irq_line_ff;
      unique case (func)
         cbm_pkg::FUNC_CPU_WRITE: begin
            priority if (in_scratch) begin
               scratch_byte_in = write_data;
            end else if (in_outer_alias) begin
               outer_bank_in = write_data;
            end else if (in_reg_window) begin
               unique case (grp)
                  cbm_pkg::GRP_OUTER:   outer_bank_in = write_data;
                  cbm_pkg::GRP_CONTROL: control_reg_in = write_data;
                  cbm_pkg::GRP_IRQ: begin
                     if (address[0]) begin
                        irq_count_in   = {write_data, irq_count_ff[7:0]};
                        irq_enabled_in = control_reg_ff[7];
                     end else begin
                        irq_count_in = {irq_count_ff[15:8], write_data};
                     end
                     irq_line_in = 1'b0;
                  end
                  default: begin
                     priority if (!lo[4]) begin
                        prg_regs_in[address[1:0]] = write_data[4:0];
                     end else if (!lo[3]) begin
                        if (cfg.chr_is_512k) begin
                           // only 10, 11, 16 and 17 select a 2k slot
                           if (lo[2:0] == 3'd0 || lo[2:0] == 3'd1 ||
                               lo[2:0] == 3'd6 || lo[2:0] == 3'd7) begin
                              chr_banks_in[chr_slot_pair] = {1'b0, write_data, 1'b0};
                              chr_banks_in[chr_slot_pair + 3'd1] =
                                 {1'b0, write_data, 1'b1};
                           end
                        end else begin
                           chr_banks_in[address[2:0]] = {outer_bank_ff[5:4], write_data};
                        end
                     end else begin
                     end
                  end
               endcase
            end else begin
            end
         end
         cbm_pkg::FUNC_CPU_TICK: begin
            if (irq_enabled_ff && (irq_count_ff != 16'd0)) begin
               irq_count_in = count_step;
               if (count_step == 16'd0) begin
                  irq_enabled_in = 1'b0;
                  irq_line_in    = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      // fixed last bank follows the outer bank outside 8k mode
      if (!control_reg_in[4]) begin
         top_window_bank_in = {outer_bank_in[5:4], 4'hF, 1'b1};
      end else begin
         top_window_bank_in = top_window_bank_ff;
      end
   end

   // prg bank for the 8000-ffff slot of this address
   always_comb begin
      if (control_reg_ff[4]) begin
         unique case (address[14:13])
            2'd0:    prg_bank = {2'b00, prg_regs_ff[0]};
            2'd1:    prg_bank = {2'b00, prg_regs_ff[1]};
            2'd2:    prg_bank = {2'b00, prg_regs_ff[2]};
            default: prg_bank = top_window_bank_ff;
         endcase
      end else begin
         unique case (address[14:13])
            2'd0:    prg_bank = {outer_bank_ff[5:0], 1'b0};
            2'd1:    prg_bank = {outer_bank_ff[5:0], 1'b1};
            2'd2:    prg_bank = {outer_bank_ff[5:4], 4'hF, 1'b0};
            default: prg_bank = top_window_bank_ff;
         endcase
      end
   end

   assign window_bank = control_reg_ff[4] ? cbm_pkg::FIXED_WINDOW_BANK : prg_regs_ff[3];
   assign ppu_offset  = address[12:0];

   // result of the item
   always_comb begin
      result             = '0;
      result.mirroring   = control_reg_in[1:0];
      result.irq         = irq_line_in;
      unique case (func)
         cbm_pkg::FUNC_CPU_READ: begin
            priority if (address == 16'h5000) begin
               result.read_data  = (cfg.switch_present && !cfg.region_asia) ? 8'h00 : 8'hFF;
               result.data_valid = 1'b1;
            end else if (in_scratch) begin
               result.read_data  = scratch_byte_ff;
               result.data_valid = 1'b1;
            end else if (address[15:13] == 3'b011) begin
               if (!cfg.wram_writable) begin
                  if (control_reg_ff[5]) begin
                     result.rom_read    = 1'b1;
                     result.rom_address = {2'b00, window_bank, address[12:0]};
                  end else begin
                     result.read_data  = address[15:8];
                     result.data_valid = 1'b1;
                  end
               end
            end else if (address[15]) begin
               result.rom_read    = 1'b1;
               result.rom_address = {prg_bank, address[12:0]};
            end else begin
            end
         end
         cbm_pkg::FUNC_PPU_READ: begin
            result.chr_address = {chr_banks_ff[ppu_offset[12:10]], ppu_offset[9:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_reg_ff     <= '0;
         prg_regs_ff        <= '{default: '0};
         outer_bank_ff      <= '0;
         scratch_byte_ff    <= '0;
         chr_banks_ff       <= '{default: '0};
         top_window_bank_ff <= cbm_pkg::TOP_WINDOW_RESET;
         irq_count_ff       <= '0;
         irq_enabled_ff     <= 1'b0;
         irq_line_ff        <= 1'b0;
      end else if (step_en) begin
         control_reg_ff     <= control_reg_in;
         prg_regs_ff        <= prg_regs_in;
         outer_bank_ff      <= outer_bank_in;
         scratch_byte_ff    <= scratch_byte_in;
         chr_banks_ff       <= chr_banks_in;
         top_window_bank_ff <= top_window_bank_in;
         irq_count_ff       <= irq_count_in;
         irq_enabled_ff     <= irq_enabled_in;
         irq_line_ff        <= irq_line_in;
      end
   end

endmodule

// ===== design/cartridge_bank_mapper_with_irq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Bank mapper with a 16-bit cycle irq counter: input register, decode and
// state update in one pass, result register.
//
//   channel | handshake          | carries
//   req     | req_valid/stall    | func, address, write_data
//   rsp     | rsp_valid/stall    | read_data .. irq, one item per req item
//   csr     | csr_valid/ready    | csr_index, csr_write_data
//
// One item per clock when rsp is not stalled; rsp_valid rises once an accepted
// item has passed the input register and then the result register.
// The mapper state updates in the cycle an item moves into the result register.
// Synchronous reset clears valid flags, configuration and mapper state.
// A stalled result holds; req stalls only when both registers are full.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_data_valid,
   output logic        rsp_rom_read,
   output logic [19:0] rsp_rom_address,
   output logic [19:0] rsp_chr_address,
   output logic [1:0]  rsp_mirroring,
   output logic        rsp_irq,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_write_data
);

   logic                in_valid_ff;
   cbm_pkg::func_type   func_ff;
   logic [15:0]         address_ff;
   logic [7:0]          write_data_ff;
   logic                out_valid_ff;
   cbm_pkg::result_type result_ff;
   cbm_pkg::result_type result_in;
   cbm_pkg::cfg_type    cfg_ff;
   logic                advance;
   logic                accept;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (cbm_pkg::csr_index_type'(csr_index))
            cbm_pkg::CSR_CHR_IS_512K:    cfg_ff.chr_is_512k    <= csr_write_data;
            cbm_pkg::CSR_WRAM_WRITABLE:  cfg_ff.wram_writable  <= csr_write_data;
            cbm_pkg::CSR_SWITCH_PRESENT: cfg_ff.switch_present <= csr_write_data;
            default:                     cfg_ff.region_asia    <= csr_write_data;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff       <= cbm_pkg::func_type'(req_func);
         address_ff    <= req_address;
         write_data_ff <= req_write_data;
      end
   end

   cbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (in_valid_ff && advance),
      .func       (func_ff),
      .address    (address_ff),
      .write_data (write_data_ff),
      .cfg        (cfg_ff),
      .result     (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = result_ff.read_data;
   assign rsp_data_valid  = result_ff.data_valid;
   assign rsp_rom_read    = result_ff.rom_read;
   assign rsp_rom_address = result_ff.rom_address;
   assign rsp_chr_address = result_ff.chr_address;
   assign rsp_mirroring   = result_ff.mirroring;
   assign rsp_irq         = result_ff.irq;

endmodule
